FILE: src/mbp_pkg.sv
`timescale 1ns / 1ps

package mbp_pkg;

  // Longest code a push may carry; longer counts are clamped to this
  localparam int MAX_CODE_BITS = 16;
  // Width of the input code field, fixed by the interface
  localparam int CODE_W        = 16;
  // Width of the input bit count field
  localparam int BC_W          = 5;
  // Up to 7 held bits plus one full code
  localparam int HELD_W        = 7;
  localparam int ACC_W         = HELD_W + MAX_CODE_BITS;
  localparam int TOT_W         = $clog2(ACC_W + 1);
  localparam int N_W           = $clog2(MAX_CODE_BITS + 1);
  // Most bytes a single push can complete
  localparam int MAX_BYTES     = ACC_W / 8;
  localparam int CNT_W         = $clog2(MAX_BYTES + 1);
  localparam int IDX_W         = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
  // Queue between front and back
  localparam int QDEPTH        = 2;
  localparam int QPTR_W        = 1;
  localparam int QCNT_W        = 2;

  // Input operation codes
  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  // One queued job: completed bytes, earliest in entry 0, and how many are valid
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [CNT_W-1:0]          cnt;
  } mbp_rec_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } mbp_qstat_t;

endpackage

FILE: src/mbp_front.sv
`timescale 1ns / 1ps

module mbp_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_op,
  input  logic [mbp_pkg::BC_W-1:0]  in_bit_count,
  input  logic [mbp_pkg::CODE_W-1:0] in_code_bits,
  input  mbp_pkg::mbp_qstat_t       q_stat,
  output logic                      push,
  output mbp_pkg::mbp_rec_t         push_rec
);
  import mbp_pkg::*;

  logic [HELD_W-1:0] held_bits_r, held_bits_nxt;
  logic [2:0]        held_count_r, held_count_nxt;

  logic              accept;
  logic [N_W-1:0]    n_eff;
  logic [ACC_W-1:0]  mask_wide;
  logic [ACC_W-1:0]  acc;
  logic [ACC_W-1:0]  aligned;
  logic [TOT_W-1:0]  total;
  logic [7:0]        hmask;
  logic [CNT_W-1:0]  cnt;

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  // Clamp the count; a flush appends nothing
  always_comb begin
    if (in_op == OP_FLUSH) begin
      n_eff = '0;
    end else if (int'(in_bit_count) > MAX_CODE_BITS) begin
      n_eff = N_W'(MAX_CODE_BITS);
    end else begin
      n_eff = N_W'(in_bit_count);
    end
  end

  // Append the code behind the held bits
  assign mask_wide = (ACC_W'(1) << n_eff) - ACC_W'(1);
  assign acc       = (ACC_W'(held_bits_r) << n_eff)
                   | (ACC_W'(in_code_bits) & mask_wide);
  assign total     = TOT_W'(held_count_r) + TOT_W'(n_eff);

  // Left-align so the earliest bit sits at the top; zero fill pads a flush
  assign aligned = acc << (TOT_W'(ACC_W) - total);

  // Job record: completed bytes and their count
  always_comb begin
    for (int k = 0; k < MAX_BYTES; k++) begin
      push_rec.bytes[k] = aligned[ACC_W-1-8*k -: 8];
    end
    push_rec.cnt = cnt;
  end

  // Byte count and remaining held bits
  assign hmask = (8'(1) << total[2:0]) - 8'(1);

  always_comb begin
    if (in_op == OP_FLUSH) begin
      cnt            = (held_count_r != 3'd0) ? CNT_W'(1) : '0;
      held_bits_nxt  = '0;
      held_count_nxt = '0;
    end else begin
      cnt            = CNT_W'(total >> 3);
      held_bits_nxt  = acc[HELD_W-1:0] & hmask[HELD_W-1:0];
      held_count_nxt = total[2:0];
    end
  end

  assign push         = accept && (cnt != '0);

  // Held state advances on every accepted transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_bits_r  <= '0;
      held_count_r <= '0;
    end else if (accept) begin
      held_bits_r  <= held_bits_nxt;
      held_count_r <= held_count_nxt;
    end
  end

endmodule

FILE: src/mbp_queue.sv
`timescale 1ns / 1ps

module mbp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mbp_pkg::mbp_rec_t   push_rec,
  input  logic                pop,
  output mbp_pkg::mbp_rec_t   pop_rec,
  output mbp_pkg::mbp_qstat_t q_stat
);
  import mbp_pkg::*;

  mbp_rec_t           slot_r [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]  count_r, count_nxt;

  assign q_stat.full  = (count_r == QCNT_W'(QDEPTH));
  assign q_stat.empty = (count_r == '0);
  assign pop_rec      = slot_r[rd_ptr_r];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_nxt = wr_ptr_r + (push ? QPTR_W'(1) : '0);
    rd_ptr_nxt = rd_ptr_r + (pop ? QPTR_W'(1) : '0);
    count_nxt  = count_r + (push ? QCNT_W'(1) : '0) - (pop ? QCNT_W'(1) : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_rec;
    end
  end

endmodule

FILE: src/mbp_back.sv
`timescale 1ns / 1ps

module mbp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mbp_pkg::mbp_qstat_t q_stat,
  input  mbp_pkg::mbp_rec_t   pop_rec,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                out_last
);
  import mbp_pkg::*;

  mbp_rec_t          cur_r;
  logic [IDX_W-1:0]  idx_r;
  logic              busy_r;
  logic              at_last;
  logic              done;

  // Current byte of the job in hand
  assign at_last   = ((CNT_W'(idx_r) + CNT_W'(1)) == cur_r.cnt);
  assign out_valid = busy_r;
  assign out_byte  = cur_r.bytes[idx_r];
  assign out_last  = at_last;

  // Take the next job when idle or when the final byte transfers
  assign done = busy_r && !out_stall && at_last;
  assign pop  = !q_stat.empty && (!busy_r || done);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else if (pop) begin
      busy_r <= 1'b1;
      idx_r  <= '0;
    end else if (busy_r && !out_stall) begin
      if (at_last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + IDX_W'(1);
      end
    end
  end

  // Job payload
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= pop_rec;
    end
  end

endmodule

FILE: src/msb_first_bit_packer.sv
`timescale 1ns / 1ps

// Channel  Direction  Handshake            Payload
// in       input      in_valid/in_stall    in_op, in_bit_count, in_code_bits
// out      output     out_valid/out_stall  out_byte, out_last
//
// A push is classified in its accept cycle and queued with its completed bytes.
// The output gives one byte per cycle unless out_stall holds it, so a code
// that completes two bytes holds the output for both; the back end sets the
// sustained rate. Items that complete no byte never reach the queue.
// in_stall rises only while the two-entry job queue is full.
// Synchronous active-low reset clears the held bits, queue and output.
module msb_first_bit_packer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_op,
  input  logic [mbp_pkg::BC_W-1:0]    in_bit_count,
  input  logic [mbp_pkg::CODE_W-1:0]  in_code_bits,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  out_byte,
  output logic                        out_last
);
  import mbp_pkg::*;

  logic       push;
  logic       pop;
  mbp_rec_t   push_rec;
  mbp_rec_t   pop_rec;
  mbp_qstat_t q_stat;

  mbp_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_op        (in_op),
    .in_bit_count (in_bit_count),
    .in_code_bits (in_code_bits),
    .q_stat       (q_stat),
    .push         (push),
    .push_rec     (push_rec)
  );

  mbp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .q_stat   (q_stat)
  );

  mbp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .pop_rec   (pop_rec),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  // Queue never overflows or underflows
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("job pushed into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("job popped from an empty queue");

  // Only jobs with one to MAX_BYTES bytes are queued
  a_job_size: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (push_rec.cnt != '0) && (int'(push_rec.cnt) <= MAX_BYTES))
    else $error("queued job has a bad byte count");

endmodule
